@@ rtl/core/pts_pkg.sv @@
package pts_pkg;

  // Field and register widths.
  localparam int unsigned TIME_W     = 64;
  localparam int unsigned FREQ_W     = 30;
  localparam int unsigned RELOAD_W   = 24;
  localparam int unsigned MS_W       = 20;
  localparam int unsigned CPU_W      = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  // Shared multiplier operand and product widths.
  localparam int unsigned MUL_W  = 32;
  localparam int unsigned MULP_W = 2 * MUL_W;

  // The frequency times milliseconds product and its division by 1000,
  // done one 20-bit digit at a time with a 10-bit running remainder.
  localparam int unsigned PROD_W    = 50;
  localparam int unsigned DIGIT_W   = 20;
  localparam int unsigned DIGITS    = 3;
  localparam int unsigned REM_W     = 10;
  localparam int unsigned PART_W    = REM_W + DIGIT_W;
  localparam int unsigned QUO_W     = DIGITS * DIGIT_W;
  localparam int unsigned DIG_CNT_W = 2;

  // Reciprocal of 1000 scaled by 2^40, exact to within one for 30-bit inputs.
  localparam int unsigned   RECIP_SHIFT   = 40;
  localparam logic [30:0]   RECIP_1000    = 31'd1099511627;
  localparam logic [REM_W:0] MS_PER_SECOND = 11'd1000;

  // Register reset values.
  localparam logic [FREQ_W-1:0]   FREQ_RESET   = 30'd62500000;
  localparam logic [RELOAD_W-1:0] RELOAD_RESET = 24'd625000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COUNTER_FREQ = 1'b0,
    REG_TICK_RELOAD  = 1'b1
  } cfg_reg_e;

  // Function codes of an input request.
  typedef enum logic [0:0] {
    FUNC_TICK = 1'b0,
    FUNC_ARM  = 1'b1
  } func_e;

  // Operations of the shared adder.
  typedef enum logic [0:0] {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    alu_op_e           op;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [TIME_W-1:0] res;
    logic              borrow;
  } alu_rsp_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MULP,
    ST_LOADP,
    ST_RECIP,
    ST_MULQ,
    ST_CORR,
    ST_ARM,
    ST_TCMP,
    ST_TADV,
    ST_TCHK,
    ST_TSYNC,
    ST_UPT,
    ST_WAKE,
    ST_WCMP,
    ST_FIN
  } state_e;

endpackage

@@ rtl/core/pts_mul.sv @@
// Shared unsigned multiplier with a registered product.
module pts_mul (
  input  logic                        clk_i,
  input  logic [pts_pkg::MUL_W-1:0]   a_i,
  input  logic [pts_pkg::MUL_W-1:0]   b_i,
  output logic [pts_pkg::MULP_W-1:0]  p_o
);

  logic [pts_pkg::MULP_W-1:0] p_q;

  // One product per cycle, available the cycle after the operands.
  always_ff @(posedge clk_i) begin
    p_q <= pts_pkg::MULP_W'(a_i) * pts_pkg::MULP_W'(b_i);
  end

  assign p_o = p_q;

endmodule

@@ rtl/core/pts_alu.sv @@
// Shared 64-bit adder and subtractor; a subtract also reports a borrow.
module pts_alu (
  input  pts_pkg::alu_req_t req_i,
  output pts_pkg::alu_rsp_t rsp_o
);

  logic                         sub;
  logic [pts_pkg::TIME_W-1:0]   b_in;
  logic [pts_pkg::TIME_W:0]     sum;

  assign sub  = (req_i.op == pts_pkg::ALU_SUB);
  assign b_in = sub ? ~req_i.b : req_i.b;

  // Subtraction is addition of the complement with a carry in.
  assign sum = {1'b0, req_i.a} + {1'b0, b_in} + {{pts_pkg::TIME_W{1'b0}}, sub};

  assign rsp_o.res    = sum[pts_pkg::TIME_W-1:0];
  assign rsp_o.borrow = sub & ~sum[pts_pkg::TIME_W];

endmodule

@@ rtl/core/per_core_tick_deadline_scheduler.sv @@
// A timer interrupt without a sleeper wake takes the short path; an arm or a
// wake converts milliseconds on the shared multiplier through ST_MULP, ST_LOADP
// and, for each product digit, ST_RECIP, ST_MULQ and ST_CORR.
// Flow: one request at a time; in_ready_o is high only when
// idle, and the finish step stalls while an untaken result holds the output.
// Reset: asynchronous, active low; deadlines and uptime clear, registers reload.
module per_core_tick_deadline_scheduler #(
  parameter int unsigned CORE_COUNT = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pts_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pts_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // Request channel.
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            func_i,
  input  logic [pts_pkg::CPU_W-1:0]       cpu_i,
  input  logic [pts_pkg::TIME_W-1:0]      now_i,
  input  logic [pts_pkg::MS_W-1:0]        interval_ms_i,
  // Result channel.
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [pts_pkg::TIME_W-1:0]      compare_value_o,
  output logic                            quantum_tick_o,
  output logic [pts_pkg::TIME_W-1:0]      tick_count_o
);

  // Only cores a 3-bit index can reach need a deadline register.
  localparam int unsigned CPU_SPAN = 1 << pts_pkg::CPU_W;
  localparam int unsigned DL_DEPTH = (CORE_COUNT < CPU_SPAN) ? CORE_COUNT : CPU_SPAN;
  localparam int unsigned DL_W     = (DL_DEPTH > 1) ? $clog2(DL_DEPTH) : 1;

  localparam int unsigned TW = pts_pkg::TIME_W;

  // Core index reduced modulo the core count by repeated subtraction.
  function automatic logic [DL_W-1:0] reduce_core(input logic [pts_pkg::CPU_W-1:0] cpu);
    logic [pts_pkg::CPU_W:0] v;
    v = {1'b0, cpu};
    for (int i = 0; i < CPU_SPAN; i++) begin
      if (32'(v) >= CORE_COUNT) begin
        v = v - (pts_pkg::CPU_W + 1)'(CORE_COUNT);
      end
    end
    return DL_W'(v);
  endfunction

  pts_pkg::state_e state_q, state_d;

  logic [pts_pkg::FREQ_W-1:0]   freq_q;
  logic [pts_pkg::RELOAD_W-1:0] reload_q;
  logic [TW-1:0]                dl_mem_q [DL_DEPTH];
  logic [TW-1:0]                uptime_q;

  // Per-request working registers.
  logic                         func_q;
  logic [DL_W-1:0]              core_q;
  logic [TW-1:0]                now_q;
  logic [pts_pkg::MS_W-1:0]     ms_q;
  logic [TW-1:0]                dl_q;
  logic [TW-1:0]                nxt_q;
  logic [TW-1:0]                cmp_q;
  logic                         real_q;

  // Millisecond conversion registers.
  logic [pts_pkg::PROD_W-1:0]   p_q;
  logic [pts_pkg::PART_W-1:0]   v_q;
  logic [pts_pkg::DIGIT_W-1:0]  q0_q;
  logic [pts_pkg::REM_W-1:0]    rem_q;
  logic [pts_pkg::QUO_W-1:0]    quo_q;
  logic [pts_pkg::DIG_CNT_W-1:0] dig_q;

  // Output register.
  logic                         out_valid_q;
  logic [TW-1:0]                out_cmp_q;
  logic                         out_real_q;
  logic [TW-1:0]                out_tick_q;

  // Shared units.
  logic [pts_pkg::MUL_W-1:0]    mul_a, mul_b;
  logic [pts_pkg::MULP_W-1:0]   mul_p;
  pts_pkg::alu_req_t            alu_req;
  pts_pkg::alu_rsp_t            alu_rsp;

  logic                         in_fire;
  logic                         out_free;
  logic                         last_digit;
  logic [pts_pkg::DIGIT_W-1:0]  digit;
  logic [pts_pkg::PART_W-1:0]   part;
  logic [pts_pkg::DIGIT_W-1:0]  q0;
  logic [pts_pkg::PART_W-1:0]   r_full;
  logic [pts_pkg::REM_W:0]      r_small;
  logic                         r_ge;
  logic [TW-1:0]                conv;
  logic [TW-1:0]                delta;
  logic                         core_zero;

  pts_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  pts_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign in_ready_o  = (state_q == pts_pkg::ST_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = ~out_valid_q | out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign compare_value_o = out_cmp_q;
  assign quantum_tick_o  = out_real_q;
  assign tick_count_o    = out_tick_q;

  // Digit of the product for the current division step, top digit first.
  always_comb begin
    case (dig_q)
      2'd0:    digit = pts_pkg::DIGIT_W'(p_q[pts_pkg::PROD_W-1:2*pts_pkg::DIGIT_W]);
      2'd1:    digit = p_q[2*pts_pkg::DIGIT_W-1:pts_pkg::DIGIT_W];
      2'd2:    digit = p_q[pts_pkg::DIGIT_W-1:0];
      default: digit = '0;
    endcase
  end

  assign part       = {rem_q, digit};
  assign last_digit = (dig_q == pts_pkg::DIG_CNT_W'(pts_pkg::DIGITS - 1));
  assign q0         = mul_p[pts_pkg::RECIP_SHIFT+pts_pkg::DIGIT_W-1:pts_pkg::RECIP_SHIFT];

  // The estimate is low by at most one; one compare fixes digit and remainder.
  assign r_full  = v_q - mul_p[pts_pkg::PART_W-1:0];
  assign r_small = r_full[pts_pkg::REM_W:0];
  assign r_ge    = (r_small >= pts_pkg::MS_PER_SECOND);

  assign conv      = TW'(quo_q);
  assign delta     = (conv == '0) ? TW'(1) : conv;
  assign core_zero = (core_q == '0);

  // Operand selection for the shared multiplier.
  always_comb begin
    case (state_q)
      pts_pkg::ST_MULP: begin
        mul_a = pts_pkg::MUL_W'(freq_q);
        mul_b = pts_pkg::MUL_W'(ms_q);
      end
      pts_pkg::ST_RECIP: begin
        mul_a = pts_pkg::MUL_W'(part);
        mul_b = pts_pkg::MUL_W'(pts_pkg::RECIP_1000);
      end
      pts_pkg::ST_MULQ: begin
        mul_a = pts_pkg::MUL_W'(q0);
        mul_b = pts_pkg::MUL_W'(pts_pkg::MS_PER_SECOND);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Operand selection for the shared adder.
  always_comb begin
    alu_req.op = pts_pkg::ALU_ADD;
    alu_req.a  = now_q;
    alu_req.b  = '0;
    case (state_q)
      pts_pkg::ST_ARM: begin
        alu_req.b = delta;
      end
      pts_pkg::ST_TCMP: begin
        alu_req.op = pts_pkg::ALU_SUB;
        alu_req.b  = dl_q;
      end
      pts_pkg::ST_TADV: begin
        alu_req.a = dl_q;
        alu_req.b = TW'(reload_q);
      end
      pts_pkg::ST_TCHK: begin
        alu_req.op = pts_pkg::ALU_SUB;
        alu_req.b  = nxt_q;
      end
      pts_pkg::ST_TSYNC: begin
        alu_req.b = TW'(reload_q);
      end
      pts_pkg::ST_UPT: begin
        alu_req.a = uptime_q;
        alu_req.b = TW'(1);
      end
      pts_pkg::ST_WAKE: begin
        alu_req.b = conv;
      end
      pts_pkg::ST_WCMP: begin
        alu_req.op = pts_pkg::ALU_SUB;
        alu_req.a  = nxt_q;
        alu_req.b  = dl_q;
      end
      default: begin
        alu_req.op = pts_pkg::ALU_ADD;
      end
    endcase
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pts_pkg::ST_IDLE: begin
        if (in_fire) begin
          if ((func_i == pts_pkg::FUNC_ARM) || (interval_ms_i != '0)) begin
            state_d = pts_pkg::ST_MULP;
          end else begin
            state_d = pts_pkg::ST_TCMP;
          end
        end
      end
      pts_pkg::ST_MULP:  state_d = pts_pkg::ST_LOADP;
      pts_pkg::ST_LOADP: state_d = pts_pkg::ST_RECIP;
      pts_pkg::ST_RECIP: state_d = pts_pkg::ST_MULQ;
      pts_pkg::ST_MULQ:  state_d = pts_pkg::ST_CORR;
      pts_pkg::ST_CORR: begin
        if (!last_digit) begin
          state_d = pts_pkg::ST_RECIP;
        end else if (func_q == pts_pkg::FUNC_ARM) begin
          state_d = pts_pkg::ST_ARM;
        end else begin
          state_d = pts_pkg::ST_TCMP;
        end
      end
      pts_pkg::ST_ARM: state_d = pts_pkg::ST_FIN;
      pts_pkg::ST_TCMP: begin
        state_d = alu_rsp.borrow ? pts_pkg::ST_WAKE : pts_pkg::ST_TADV;
      end
      pts_pkg::ST_TADV: state_d = pts_pkg::ST_TCHK;
      pts_pkg::ST_TCHK: begin
        state_d = alu_rsp.borrow ? pts_pkg::ST_UPT : pts_pkg::ST_TSYNC;
      end
      pts_pkg::ST_TSYNC: state_d = pts_pkg::ST_UPT;
      pts_pkg::ST_UPT:   state_d = pts_pkg::ST_WAKE;
      pts_pkg::ST_WAKE: begin
        state_d = (ms_q != '0) ? pts_pkg::ST_WCMP : pts_pkg::ST_FIN;
      end
      pts_pkg::ST_WCMP: state_d = pts_pkg::ST_FIN;
      pts_pkg::ST_FIN: begin
        if (out_free) begin
          state_d = pts_pkg::ST_IDLE;
        end
      end
      default: state_d = pts_pkg::ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pts_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q   <= pts_pkg::FREQ_RESET;
      reload_q <= pts_pkg::RELOAD_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == pts_pkg::REG_COUNTER_FREQ) begin
        freq_q <= cfg_data_i[pts_pkg::FREQ_W-1:0];
      end
      if (cfg_index_i == pts_pkg::REG_TICK_RELOAD) begin
        reload_q <= cfg_data_i[pts_pkg::RELOAD_W-1:0];
      end
    end
  end

  // Per-core deadlines and the uptime count; a finished request commits here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DL_DEPTH; i++) begin
        dl_mem_q[i] <= '0;
      end
      uptime_q <= '0;
    end else begin
      if (state_q == pts_pkg::ST_FIN) begin
        dl_mem_q[core_q] <= dl_q;
      end
      if ((state_q == pts_pkg::ST_UPT) && core_zero) begin
        uptime_q <= alu_rsp.res;
      end
    end
  end

  // Working registers of the request in progress.
  always_ff @(posedge clk_i) begin
    case (state_q)
      pts_pkg::ST_IDLE: begin
        if (in_fire) begin
          func_q <= func_i;
          core_q <= reduce_core(cpu_i);
          now_q  <= now_i;
          dl_q   <= dl_mem_q[reduce_core(cpu_i)];
          real_q <= 1'b0;
          if ((func_i == pts_pkg::FUNC_ARM) && (interval_ms_i == '0)) begin
            ms_q <= pts_pkg::MS_W'(1);
          end else begin
            ms_q <= interval_ms_i;
          end
        end
      end
      pts_pkg::ST_MULP: begin
        rem_q <= '0;
        quo_q <= '0;
        dig_q <= '0;
      end
      pts_pkg::ST_LOADP: begin
        p_q <= mul_p[pts_pkg::PROD_W-1:0];
      end
      pts_pkg::ST_RECIP: begin
        v_q <= part;
      end
      pts_pkg::ST_MULQ: begin
        q0_q <= q0;
      end
      pts_pkg::ST_CORR: begin
        quo_q <= {quo_q[pts_pkg::QUO_W-pts_pkg::DIGIT_W-1:0],
                  q0_q + pts_pkg::DIGIT_W'(r_ge)};
        rem_q <= r_ge ? pts_pkg::REM_W'(r_small - pts_pkg::MS_PER_SECOND)
                      : pts_pkg::REM_W'(r_small);
        dig_q <= dig_q + pts_pkg::DIG_CNT_W'(1);
      end
      pts_pkg::ST_ARM: begin
        dl_q  <= alu_rsp.res;
        cmp_q <= alu_rsp.res;
      end
      pts_pkg::ST_TCMP: begin
        real_q <= ~alu_rsp.borrow;
      end
      pts_pkg::ST_TADV: begin
        nxt_q <= alu_rsp.res;
      end
      pts_pkg::ST_TCHK: begin
        if (alu_rsp.borrow) begin
          dl_q <= nxt_q;
        end
      end
      pts_pkg::ST_TSYNC: begin
        dl_q <= alu_rsp.res;
      end
      pts_pkg::ST_WAKE: begin
        nxt_q <= alu_rsp.res;
        cmp_q <= dl_q;
      end
      pts_pkg::ST_WCMP: begin
        if (alu_rsp.borrow) begin
          cmp_q <= nxt_q;
        end
      end
      default: begin
        cmp_q <= cmp_q;
      end
    endcase
  end

  // Output register; it holds a result until the consumer takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_cmp_q   <= '0;
      out_real_q  <= 1'b0;
      out_tick_q  <= '0;
    end else if ((state_q == pts_pkg::ST_FIN) && out_free) begin
      out_valid_q <= 1'b1;
      out_cmp_q   <= cmp_q;
      out_real_q  <= real_q;
      out_tick_q  <= uptime_q;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

@@ rtl/core/pts_checker.sv @@
// Port-level checks of the scheduler.
module pts_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [pts_pkg::TIME_W-1:0]      compare_value_o,
  input logic                            quantum_tick_o,
  input logic [pts_pkg::TIME_W-1:0]      tick_count_o
);

  // A result that is not taken holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(compare_value_o)
      && $stable(quantum_tick_o) && $stable(tick_count_o))
    else $error("result changed while stalled");

  // The block is busy in the cycle after it takes a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted back to back");

  // A new result only appears while a request is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without a request");

  // The uptime count on the port only moves when a new result is loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(tick_count_o) |-> out_valid_o && !in_ready_o == 1'b0
      && ($past(!out_valid_o) || $past(out_ready_i)))
    else $error("uptime count changed outside a result load");

  // Reset leaves the block idle with no result pending.
  assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o && in_ready_o)
    else $error("not idle in reset");

endmodule

bind per_core_tick_deadline_scheduler pts_checker u_pts_checker (.*);
